// File: rtl/vccd_pkg.sv
// Shared types, codes and constants of the Voronoi cell crossing detector.
package vccd_pkg;

  localparam int DEF_MAX_COORDS   = 4;
  localparam int DEF_MAX_CELLS    = 16;
  localparam int DEF_MAX_EDGES    = 32;

  localparam int COORD_W          = 24;
  localparam int NUM_COORD_FIELDS = 4;
  localparam int SQ_W             = 2 * (COORD_W + 1);
  localparam int IDX_W            = 5;
  localparam int EP_W             = 4;
  localparam int NB_DEPTH         = 1 << EP_W;
  localparam int STEP_W           = 32;
  localparam int REC_W            = 16;
  localparam int STATUS_W         = 4;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 5;
  localparam int CCNT_W           = 3;
  localparam int CELLCNT_W        = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_COORD_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_EDGE = 2'd2;

  typedef enum logic [1:0] {
    OP_ANCHOR  = 2'd0,
    OP_EDGE    = 2'd1,
    OP_OBSERVE = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 4'd0,
    ST_IGNORED     = 4'd1,
    ST_INIT_TIE    = 4'd2,
    ST_INIT_OFF    = 4'd3,
    ST_NONADJ_TIE  = 4'd4,
    ST_MULTI_TIE   = 4'd5,
    ST_CELL_TIE    = 4'd6,
    ST_NONADJ_JUMP = 4'd7,
    ST_BAD_INDEX   = 4'd8
  } status_t;

  typedef struct packed {
    logic [1:0]                operation;
    logic [IDX_W-1:0]          table_index;
    logic [EP_W-1:0]           endpoint_first;
    logic [EP_W-1:0]           endpoint_second;
    logic signed [COORD_W-1:0] coord_0;
    logic signed [COORD_W-1:0] coord_1;
    logic signed [COORD_W-1:0] coord_2;
    logic signed [COORD_W-1:0] coord_3;
    logic [STEP_W-1:0]         step_number;
    logic                      commit;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [EP_W-1:0]     current_cell;
    logic                started;
    logic                hit;
    logic [EP_W-1:0]     hit_origin_cell;
    logic [EP_W-1:0]     hit_target_cell;
    logic [IDX_W-1:0]    hit_edge;
    logic [STEP_W-1:0]   hit_step_number;
    logic [REC_W-1:0]    recross_total;
  } out_item_t;

  typedef struct packed {
    logic            busy;
    logic            src_valid;
    logic [EP_W-1:0] src_first;
    logic [EP_W-1:0] src_second;
  } edge_stat_t;

endpackage

// File: rtl/vccd_lane.sv
// One coordinate lane: anchor memory for that coordinate and a squared difference stage.
module vccd_lane
  import vccd_pkg::*;
#(
  parameter int MAX_CELLS = DEF_MAX_CELLS,
  localparam int CELL_W = $clog2(MAX_CELLS)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [CELL_W-1:0]         wr_addr,
  input  logic signed [COORD_W-1:0] wr_data,
  input  logic [CELL_W-1:0]         rd_addr,
  input  logic signed [COORD_W-1:0] obs,
  input  logic                      lane_on,
  output logic [SQ_W-1:0]           sq_r
);

  logic signed [COORD_W-1:0] anchor_mem [MAX_CELLS];
  logic signed [COORD_W-1:0] rd_r;
  logic [COORD_W:0]          delta;
  logic [COORD_W:0]          mag;
  logic [SQ_W-1:0]           prod;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      anchor_mem[wr_addr] <= wr_data;
    end
    rd_r <= anchor_mem[rd_addr];
  end

  always_comb begin
    delta = {obs[COORD_W-1], obs} - {rd_r[COORD_W-1], rd_r};
    mag   = delta[COORD_W] ? (~delta + 1'b1) : delta;
    prod  = mag * mag;
  end

  always_ff @(posedge clk) begin
    sq_r <= lane_on ? prod : '0;
  end

endmodule

// File: rtl/vccd_merge.sv
// Merging stage: sums the lane squares into a distance and tracks the nearest cell.
module vccd_merge
  import vccd_pkg::*;
#(
  parameter int MAX_COORDS = DEF_MAX_COORDS,
  parameter int MAX_CELLS  = DEF_MAX_CELLS,
  localparam int CELL_W = $clog2(MAX_CELLS),
  localparam int DIST_W = SQ_W + $clog2(MAX_COORDS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [SQ_W-1:0]      sq [MAX_COORDS],
  input  logic                 in_valid,
  input  logic [CELL_W-1:0]    in_cell,
  input  logic                 track,
  input  logic                 clear,
  input  logic [CELLCNT_W-1:0] cell_limit,
  input  logic [CELL_W-1:0]    occ,
  output logic [DIST_W-1:0]    dist_r,
  output logic                 dist_valid_r,
  output logic [CELL_W-1:0]    dist_cell_r,
  output logic [DIST_W-1:0]    best_r,
  output logic [CELL_W-1:0]    best_cell_r,
  output logic                 found_r,
  output logic                 multi_r,
  output logic [DIST_W-1:0]    occ_dist_r
);

  logic [DIST_W-1:0] sum;
  logic              in_range;

  always_comb begin
    sum = '0;
    for (int c = 0; c < MAX_COORDS; c++) begin
      sum = sum + DIST_W'(sq[c]);
    end
    in_range = 32'(dist_cell_r) < 32'(cell_limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_valid_r <= 1'b0;
      found_r      <= 1'b0;
      multi_r      <= 1'b0;
    end else begin
      dist_valid_r <= in_valid;
      if (clear) begin
        found_r <= 1'b0;
        multi_r <= 1'b0;
      end else if (dist_valid_r && track && in_range) begin
        if (!found_r || dist_r < best_r) begin
          found_r <= 1'b1;
          multi_r <= 1'b0;
        end else if (dist_r == best_r) begin
          multi_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    dist_r      <= sum;
    dist_cell_r <= in_cell;
    if (dist_valid_r && track && in_range && (!found_r || dist_r < best_r)) begin
      best_r      <= dist_r;
      best_cell_r <= dist_cell_r;
    end
    if (dist_valid_r && track && dist_cell_r == occ) begin
      occ_dist_r <= dist_r;
    end
  end

endmodule

// File: rtl/vccd_edges.sv
// Interface table with a sequential scan that finds the lowest interface to each neighbor.
module vccd_edges
  import vccd_pkg::*;
#(
  parameter int MAX_EDGES = DEF_MAX_EDGES,
  localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [EIDX_W-1:0] wr_addr,
  input  logic [EP_W-1:0]   wr_first,
  input  logic [EP_W-1:0]   wr_second,
  input  logic              scan_start,
  input  logic [EP_W-1:0]   occ_cell,
  input  logic              occ_ok,
  input  logic [IDX_W-1:0]  src_edge,
  input  logic [EP_W-1:0]   look_cell,
  input  logic              look_ok,
  output edge_stat_t        stat,
  output logic              look_found,
  output logic [EIDX_W-1:0] look_edge
);

  logic [2*EP_W-1:0] edge_mem [MAX_EDGES];
  logic [MAX_EDGES-1:0] valid_r;
  logic              run_r;
  logic [EIDX_W-1:0] scan_idx_r;
  logic              pv_r;
  logic              pvalid_r;
  logic [EIDX_W-1:0] pidx_r;
  logic [2*EP_W-1:0] pdata_r;
  logic [NB_DEPTH-1:0] nb_found_r;
  logic [EIDX_W-1:0] nb_edge_r [NB_DEPTH];
  logic              src_valid_r;
  logic [EP_W-1:0]   src_first_r;
  logic [EP_W-1:0]   src_second_r;
  logic [EP_W-1:0]   pf;
  logic [EP_W-1:0]   ps;
  logic [EP_W-1:0]   other;
  logic              touch;
  logic              new_nb;
  logic              at_src;

  always_comb begin
    pf     = pdata_r[2*EP_W-1:EP_W];
    ps     = pdata_r[EP_W-1:0];
    touch  = occ_ok && (pf == occ_cell || ps == occ_cell);
    other  = (pf == occ_cell) ? ps : pf;
    // Only the lowest-indexed valid interface seen for a neighbor counts.
    new_nb = pv_r && pvalid_r && touch && !nb_found_r[other];
    at_src = pv_r && (32'(pidx_r) == 32'(src_edge));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      edge_mem[wr_addr] <= {wr_first, wr_second};
    end
    pdata_r <= edge_mem[scan_idx_r];
    pidx_r  <= scan_idx_r;
    if (new_nb) begin
      nb_edge_r[other] <= pidx_r;
    end
    if (at_src) begin
      src_first_r  <= pf;
      src_second_r <= ps;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      run_r       <= 1'b0;
      scan_idx_r  <= '0;
      pv_r        <= 1'b0;
      pvalid_r    <= 1'b0;
      nb_found_r  <= '0;
      src_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      pv_r     <= run_r;
      pvalid_r <= valid_r[scan_idx_r];
      if (scan_start) begin
        run_r       <= 1'b1;
        scan_idx_r  <= '0;
        nb_found_r  <= '0;
        src_valid_r <= 1'b0;
      end else begin
        if (run_r) begin
          scan_idx_r <= scan_idx_r + 1'b1;
          if (scan_idx_r == EIDX_W'(MAX_EDGES - 1)) begin
            run_r <= 1'b0;
          end
        end
        if (new_nb) begin
          nb_found_r[other] <= 1'b1;
        end
        if (at_src) begin
          src_valid_r <= pvalid_r;
        end
      end
    end
  end

  always_comb begin
    stat.busy       = run_r | pv_r;
    stat.src_valid  = src_valid_r;
    stat.src_first  = src_first_r;
    stat.src_second = src_second_r;
    look_found      = look_ok && nb_found_r[look_cell];
    look_edge       = nb_edge_r[look_cell];
  end

endmodule

// File: rtl/voronoi_cell_crossing_detector.sv
// Top level: command decode, tracking state and the observation sequencer.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-------------------------------
//  input    | start, busy, in_item           | taken when start && !busy
//  result   | out_strobe, out_item           | one-cycle strobe, no stall
//  config   | cfg_wr_en, cfg_index, cfg_data | written when cfg_wr_en is high
//
// Table writes, restart and ignored observations give their result in the next cycle.
// A committed observation runs the anchor pass (one cell per cycle through the lane
// memories) alongside the interface scan; an exact tie with the occupied cell adds a
// second anchor pass.
// Reset is synchronous; tables need no clearing pass, only interface valid bits clear.
// The receiver cannot stall, so each transaction's result leaves as soon as it is known.
module voronoi_cell_crossing_detector
  import vccd_pkg::*;
#(
  parameter int MAX_COORDS = DEF_MAX_COORDS,
  parameter int MAX_CELLS  = DEF_MAX_CELLS,
  parameter int MAX_EDGES  = DEF_MAX_EDGES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_strobe,
  output out_item_t             out_item,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CELL_W = $clog2(MAX_CELLS);
  localparam int DIST_W = SQ_W + $clog2(MAX_COORDS);
  localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_TIE  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  in_item_t item_r;
  logic accept;

  logic [CCNT_W-1:0]    ccnt_r;
  logic [CELLCNT_W-1:0] cellcnt_r;
  logic [IDX_W-1:0]     src_r;

  logic [CELL_W-1:0] occ_r, occ_nxt;
  logic started_r, started_nxt;
  logic hit_r, hit_nxt;
  logic [CELL_W-1:0] hit_origin_r, hit_origin_nxt;
  logic [CELL_W-1:0] hit_target_r, hit_target_nxt;
  logic [EIDX_W-1:0] hit_edge_r, hit_edge_nxt;
  logic [STEP_W-1:0] hit_step_r, hit_step_nxt;
  logic [REC_W-1:0]  recross_r, recross_nxt;

  logic tie_done_r, tie_done_nxt;
  status_t tie_status_r, tie_status_nxt;
  logic tie_have_r, tie_have_nxt;
  logic [CELL_W-1:0] tie_cell_r, tie_cell_nxt;
  logic [EIDX_W-1:0] tie_edge_r, tie_edge_nxt;

  logic iss_on_r;
  logic [CELL_W-1:0] iss_cell_r;
  logic iss_start;
  logic start_scan;
  logic [1:0] tag_v_r;
  logic [CELL_W-1:0] tag_cell_r [2];
  logic pipe_idle;

  logic fin;
  status_t fin_status;
  logic wr_anchor;
  logic wr_edge;
  logic geo_bad;

  out_item_t out_item_r, out_nxt;
  logic out_strobe_r;

  logic signed [COORD_W-1:0] in_coords [NUM_COORD_FIELDS];
  logic signed [COORD_W-1:0] obs_coords [NUM_COORD_FIELDS];
  logic [SQ_W-1:0] sq [MAX_COORDS];

  logic [DIST_W-1:0] scan_dist;
  logic dist_valid;
  logic [CELL_W-1:0] dist_cell;
  logic [DIST_W-1:0] best;
  logic [CELL_W-1:0] best_cell;
  logic found;
  logic multi;
  logic [DIST_W-1:0] occ_dist;

  edge_stat_t edge_stat;
  logic [CELL_W-1:0] look_sel;
  logic look_found;
  logic [EIDX_W-1:0] look_edge;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  assign in_coords[0]  = in_item.coord_0;
  assign in_coords[1]  = in_item.coord_1;
  assign in_coords[2]  = in_item.coord_2;
  assign in_coords[3]  = in_item.coord_3;
  assign obs_coords[0] = item_r.coord_0;
  assign obs_coords[1] = item_r.coord_1;
  assign obs_coords[2] = item_r.coord_2;
  assign obs_coords[3] = item_r.coord_3;

  for (genvar c = 0; c < MAX_COORDS; c++) begin : g_lane
    logic signed [COORD_W-1:0] lane_wr;
    logic signed [COORD_W-1:0] lane_obs;
    if (c < NUM_COORD_FIELDS) begin : g_field
      assign lane_wr  = in_coords[c];
      assign lane_obs = obs_coords[c];
    end else begin : g_zero
      assign lane_wr  = '0;
      assign lane_obs = '0;
    end
    vccd_lane #(
      .MAX_CELLS(MAX_CELLS)
    ) u_lane (
      .clk     (clk),
      .wr_en   (wr_anchor),
      .wr_addr (CELL_W'(in_item.table_index)),
      .wr_data (lane_wr),
      .rd_addr (iss_cell_r),
      .obs     (lane_obs),
      .lane_on (32'(ccnt_r) > c),
      .sq_r    (sq[c])
    );
  end

  vccd_merge #(
    .MAX_COORDS(MAX_COORDS),
    .MAX_CELLS (MAX_CELLS)
  ) u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .sq           (sq),
    .in_valid     (tag_v_r[1]),
    .in_cell      (tag_cell_r[1]),
    .track        (state_r == S_SCAN),
    .clear        (start_scan),
    .cell_limit   (cellcnt_r),
    .occ          (occ_r),
    .dist_r       (scan_dist),
    .dist_valid_r (dist_valid),
    .dist_cell_r  (dist_cell),
    .best_r       (best),
    .best_cell_r  (best_cell),
    .found_r      (found),
    .multi_r      (multi),
    .occ_dist_r   (occ_dist)
  );

  assign look_sel = (state_r == S_TIE) ? dist_cell : best_cell;

  vccd_edges #(
    .MAX_EDGES(MAX_EDGES)
  ) u_edges (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_edge),
    .wr_addr    (EIDX_W'(in_item.table_index)),
    .wr_first   (in_item.endpoint_first),
    .wr_second  (in_item.endpoint_second),
    .scan_start (start_scan),
    .occ_cell   (EP_W'(occ_r)),
    .occ_ok     (32'(occ_r) < NB_DEPTH),
    .src_edge   (src_r),
    .look_cell  (EP_W'(look_sel)),
    .look_ok    (32'(look_sel) < NB_DEPTH),
    .stat       (edge_stat),
    .look_found (look_found),
    .look_edge  (look_edge)
  );

  assign pipe_idle = !iss_on_r && (tag_v_r == '0) && !dist_valid;

  always_comb begin
    geo_bad = (ccnt_r == '0) || (32'(ccnt_r) > MAX_COORDS) ||
              (cellcnt_r < CELLCNT_W'(2)) || (32'(cellcnt_r) > MAX_CELLS) ||
              !edge_stat.src_valid;
  end

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    started_nxt    = started_r;
    hit_nxt        = hit_r;
    hit_origin_nxt = hit_origin_r;
    hit_target_nxt = hit_target_r;
    hit_edge_nxt   = hit_edge_r;
    hit_step_nxt   = hit_step_r;
    recross_nxt    = recross_r;
    tie_done_nxt   = tie_done_r;
    tie_status_nxt = tie_status_r;
    tie_have_nxt   = tie_have_r;
    tie_cell_nxt   = tie_cell_r;
    tie_edge_nxt   = tie_edge_r;
    fin            = 1'b0;
    fin_status     = ST_OK;
    wr_anchor      = 1'b0;
    wr_edge        = 1'b0;
    start_scan     = 1'b0;
    iss_start      = 1'b0;

    if (accept) begin
      unique case (op_t'(in_item.operation))
        OP_ANCHOR: begin
          fin = 1'b1;
          if (32'(in_item.table_index) < MAX_CELLS) begin
            wr_anchor = 1'b1;
          end else begin
            fin_status = ST_BAD_INDEX;
          end
        end
        OP_EDGE: begin
          fin = 1'b1;
          if (32'(in_item.table_index) < MAX_EDGES) begin
            wr_edge = 1'b1;
          end else begin
            fin_status = ST_BAD_INDEX;
          end
        end
        OP_OBSERVE: begin
          if (!in_item.commit || hit_r) begin
            fin        = 1'b1;
            fin_status = ST_IGNORED;
          end else begin
            start_scan = 1'b1;
            iss_start  = 1'b1;
            state_nxt  = S_SCAN;
          end
        end
        OP_RESTART: begin
          fin            = 1'b1;
          occ_nxt        = '0;
          started_nxt    = 1'b0;
          hit_nxt        = 1'b0;
          hit_origin_nxt = '0;
          hit_target_nxt = '0;
          hit_edge_nxt   = '0;
          hit_step_nxt   = '0;
          recross_nxt    = '0;
        end
        default: begin
        end
      endcase
    end else if (state_r == S_SCAN) begin
      if (pipe_idle && !edge_stat.busy) begin
        fin       = 1'b1;
        state_nxt = S_IDLE;
        if (geo_bad) begin
          fin_status = ST_BAD_INDEX;
        end else if (!started_r) begin
          if (!found || multi) begin
            fin_status = ST_INIT_TIE;
          end else if (32'(best_cell) != 32'(edge_stat.src_first) &&
                       32'(best_cell) != 32'(edge_stat.src_second)) begin
            fin_status = ST_INIT_OFF;
          end else begin
            occ_nxt     = best_cell;
            started_nxt = 1'b1;
          end
        end else if (occ_dist == best) begin
          // The occupied cell is among the nearest: look at every tied neighbor.
          fin          = 1'b0;
          state_nxt    = S_TIE;
          iss_start    = 1'b1;
          tie_done_nxt = 1'b0;
          tie_have_nxt = 1'b0;
        end else if (multi) begin
          fin_status = ST_CELL_TIE;
        end else if (!look_found) begin
          fin_status = ST_NONADJ_JUMP;
        end else if (32'(look_edge) == 32'(src_r)) begin
          occ_nxt = best_cell;
          if (recross_r != '1) begin
            recross_nxt = recross_r + 1'b1;
          end
        end else begin
          hit_nxt        = 1'b1;
          hit_step_nxt   = item_r.step_number;
          hit_origin_nxt = occ_r;
          hit_target_nxt = best_cell;
          hit_edge_nxt   = look_edge;
        end
      end
    end else if (state_r == S_TIE) begin
      if (dist_valid && !tie_done_r && (32'(dist_cell) < 32'(cellcnt_r)) &&
          dist_cell != occ_r && scan_dist == best) begin
        if (!look_found) begin
          tie_done_nxt   = 1'b1;
          tie_status_nxt = ST_NONADJ_TIE;
        end else if (32'(look_edge) == 32'(src_r)) begin
          tie_done_nxt = tie_done_r;
        end else if (tie_have_r) begin
          tie_done_nxt   = 1'b1;
          tie_status_nxt = ST_MULTI_TIE;
        end else begin
          tie_have_nxt = 1'b1;
          tie_cell_nxt = dist_cell;
          tie_edge_nxt = look_edge;
        end
      end
      if (pipe_idle) begin
        fin       = 1'b1;
        state_nxt = S_IDLE;
        if (tie_done_r) begin
          fin_status = tie_status_r;
        end else if (tie_have_r) begin
          hit_nxt        = 1'b1;
          hit_step_nxt   = item_r.step_number;
          hit_origin_nxt = occ_r;
          hit_target_nxt = tie_cell_r;
          hit_edge_nxt   = tie_edge_r;
        end
      end
    end
  end

  always_comb begin
    out_nxt.status          = fin_status;
    out_nxt.current_cell    = started_nxt ? EP_W'(occ_nxt) : '0;
    out_nxt.started         = started_nxt;
    out_nxt.hit             = hit_nxt;
    out_nxt.hit_origin_cell = hit_nxt ? EP_W'(hit_origin_nxt) : '0;
    out_nxt.hit_target_cell = hit_nxt ? EP_W'(hit_target_nxt) : '0;
    out_nxt.hit_edge        = hit_nxt ? IDX_W'(hit_edge_nxt) : '0;
    out_nxt.hit_step_number = hit_nxt ? hit_step_nxt : '0;
    out_nxt.recross_total   = recross_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ccnt_r       <= CCNT_W'(1);
      cellcnt_r    <= CELLCNT_W'(2);
      src_r        <= '0;
      occ_r        <= '0;
      started_r    <= 1'b0;
      hit_r        <= 1'b0;
      hit_origin_r <= '0;
      hit_target_r <= '0;
      hit_edge_r   <= '0;
      hit_step_r   <= '0;
      recross_r    <= '0;
      tie_done_r   <= 1'b0;
      tie_have_r   <= 1'b0;
      iss_on_r     <= 1'b0;
      iss_cell_r   <= '0;
      tag_v_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      started_r    <= started_nxt;
      hit_r        <= hit_nxt;
      hit_origin_r <= hit_origin_nxt;
      hit_target_r <= hit_target_nxt;
      hit_edge_r   <= hit_edge_nxt;
      hit_step_r   <= hit_step_nxt;
      recross_r    <= recross_nxt;
      tie_done_r   <= tie_done_nxt;
      tie_have_r   <= tie_have_nxt;
      out_strobe_r <= fin;
      tag_v_r      <= {tag_v_r[0], iss_on_r};
      if (iss_start) begin
        iss_on_r   <= 1'b1;
        iss_cell_r <= '0;
      end else if (iss_on_r) begin
        iss_cell_r <= iss_cell_r + 1'b1;
        if (iss_cell_r == CELL_W'(MAX_CELLS - 1)) begin
          iss_on_r <= 1'b0;
        end
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_COORD_COUNT: ccnt_r    <= cfg_data[CCNT_W-1:0];
          CFG_CELL_COUNT:  cellcnt_r <= cfg_data;
          CFG_SOURCE_EDGE: src_r     <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    tie_status_r  <= tie_status_nxt;
    tie_cell_r    <= tie_cell_nxt;
    tie_edge_r    <= tie_edge_nxt;
    tag_cell_r[0] <= iss_cell_r;
    tag_cell_r[1] <= tag_cell_r[0];
    if (fin) begin
      out_item_r <= out_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_hit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (hit_r && !(accept && in_item.operation == OP_RESTART)) |=> hit_r)
    else $error("terminal hit dropped without a restart");

  a_recross_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && in_item.operation == OP_RESTART) |=> (recross_r >= $past(recross_r)))
    else $error("recrossing count went down without a restart");

  a_hit_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    hit_r |-> started_r)
    else $error("terminal hit latched before tracking started");

  a_idle_no_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !iss_on_r)
    else $error("anchor pass still running while idle");

endmodule
